>>> src/ack_nak_packet_stream_receiver_core_assert.svh
// assertion macros shared by the receiver core modules
`ifndef ACK_NAK_PACKET_STREAM_RECEIVER_CORE_ASSERT_SVH
`define ACK_NAK_PACKET_STREAM_RECEIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define ANBR_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define ANBR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ANBR_ASSERT_CLK(label, clk, rst, prop, msg)
`define ANBR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> src/anbr_pkg.sv
// types and constants of the ack/nak packet stream receiver
package anbr_pkg;

   // reply and marker bytes
   localparam logic [7:0] BYTE_RECV_DATA = 8'h07;
   localparam logic [7:0] MARK_START     = 8'h14;
   localparam logic [7:0] MARK_PACKET    = 8'h15;
   localparam logic [7:0] MARK_END       = 8'h16;
   localparam logic [7:0] BYTE_ACK       = 8'h17;
   localparam logic [7:0] BYTE_NAK       = 8'h18;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_BYTE  = 1'b1;

   // csr register indexes
   localparam logic CSR_LEN_CHECK_EN = 1'b0;
   localparam logic CSR_EXP_TOTAL    = 1'b1;

   // receiver phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HDRMARK = 3'd1;
   localparam logic [2:0] PH_HDRLEN  = 3'd2;
   localparam logic [2:0] PH_MARKER  = 3'd3;
   localparam logic [2:0] PH_PKTLEN  = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_DONE    = 3'd6;
   localparam logic [2:0] PH_FAILED  = 3'd7;

   // configuration register contents
   typedef struct packed {
      logic        len_check_en;
      logic [31:0] exp_total;
   } cfg_type;

   // one response item
   typedef struct packed {
      logic        reply_valid;
      logic [7:0]  reply_byte;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        transfer_done;
      logic        transfer_failed;
      logic [31:0] declared_length;
      logic [31:0] bytes_received;
   } result_type;

endpackage

>>> src/anbr_chan_if.sv
// request and response channel interfaces of the receiver core
interface anbr_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface anbr_rsp_if;
   logic        valid;
   logic        ready;
   logic        reply_valid;
   logic [7:0]  reply_byte;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic        transfer_done;
   logic        transfer_failed;
   logic [31:0] declared_length;
   logic [31:0] bytes_received;

   modport source (
      output valid, output reply_valid, output reply_byte, output payload_valid,
      output payload_byte, output transfer_done, output transfer_failed,
      output declared_length, output bytes_received, input ready
   );
   modport sink (
      input valid, input reply_valid, input reply_byte, input payload_valid,
      input payload_byte, input transfer_done, input transfer_failed,
      input declared_length, input bytes_received, output ready
   );
endinterface

>>> src/anbr_fsm.sv
// framing state machine: phase, counters and per-request result
`include "ack_nak_packet_stream_receiver_core_assert.svh"
module anbr_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 req_type,
   input  logic [7:0]           rx_byte,
   input  anbr_pkg::cfg_type    cfg,
   output anbr_pkg::result_type result
);
   import anbr_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hdr_idx_ff, hdr_idx_in;
   logic [31:0] ann_len_ff, ann_len_in;
   logic [15:0] pkt_left_ff, pkt_left_in;
   logic [31:0] rcv_cnt_ff, rcv_cnt_in;
   logic        rv, pv;
   logic [7:0]  rb, pb;

   // next state and reply for the accepted request
   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      ann_len_in  = ann_len_ff;
      pkt_left_in = pkt_left_ff;
      rcv_cnt_in  = rcv_cnt_ff;
      rv = 1'b0;
      rb = 8'h00;
      pv = 1'b0;
      pb = 8'h00;
      if (accept) begin
         if (req_type == REQ_START) begin
            phase_in    = PH_HDRMARK;
            hdr_idx_in  = 2'd0;
            ann_len_in  = 32'd0;
            pkt_left_in = 16'd0;
            rcv_cnt_in  = 32'd0;
            rv = 1'b1;
            rb = BYTE_RECV_DATA;
         end else begin
            case (phase_ff)
               PH_HDRMARK: begin
                  if (rx_byte == MARK_START) begin
                     phase_in   = PH_HDRLEN;
                     hdr_idx_in = 2'd0;
                  end else begin
                     phase_in = PH_FAILED;
                     rv = 1'b1;
                     rb = BYTE_NAK;
                  end
               end
               PH_HDRLEN: begin
                  ann_len_in = {ann_len_ff[23:0], rx_byte};
                  if (hdr_idx_ff == 2'd3) begin
                     hdr_idx_in = 2'd0;
                     phase_in   = PH_MARKER;
                     rv = 1'b1;
                     rb = BYTE_ACK;
                  end else begin
                     hdr_idx_in = 2'(hdr_idx_ff + 2'd1);
                  end
               end
               PH_MARKER: begin
                  if (rx_byte == MARK_PACKET) begin
                     phase_in    = PH_PKTLEN;
                     hdr_idx_in  = 2'd0;
                     pkt_left_in = 16'd0;
                  end else if (rx_byte == MARK_END) begin
                     phase_in = PH_DONE;
                     rv = 1'b1;
                     rb = (cfg.len_check_en && rcv_cnt_ff != cfg.exp_total) ?
                          BYTE_NAK : BYTE_ACK;
                  end else begin
                     rv = 1'b1;
                     rb = BYTE_ACK;
                  end
               end
               PH_PKTLEN: begin
                  pkt_left_in = {pkt_left_ff[7:0], rx_byte};
                  if (hdr_idx_ff == 2'd1) begin
                     hdr_idx_in = 2'd0;
                     if (pkt_left_in == 16'd0) begin
                        phase_in = PH_MARKER;
                        rv = 1'b1;
                        rb = BYTE_ACK;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else begin
                     hdr_idx_in = 2'd1;
                  end
               end
               PH_PAYLOAD: begin
                  pv = 1'b1;
                  pb = rx_byte;
                  rcv_cnt_in  = 32'(rcv_cnt_ff + 32'd1);
                  pkt_left_in = 16'(pkt_left_ff - 16'd1);
                  if (pkt_left_in == 16'd0) begin
                     phase_in = PH_MARKER;
                     rv = 1'b1;
                     rb = BYTE_ACK;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // result fields reflect the state after the request
   always_comb begin
      result.reply_valid     = rv;
      result.reply_byte      = rb;
      result.payload_valid   = pv;
      result.payload_byte    = pb;
      result.transfer_done   = (phase_in == PH_DONE);
      result.transfer_failed = (phase_in == PH_FAILED);
      result.declared_length = ann_len_in;
      result.bytes_received  = rcv_cnt_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hdr_idx_ff  <= 2'd0;
         ann_len_ff  <= 32'd0;
         pkt_left_ff <= 16'd0;
         rcv_cnt_ff  <= 32'd0;
      end else begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         ann_len_ff  <= ann_len_in;
         pkt_left_ff <= pkt_left_in;
         rcv_cnt_ff  <= rcv_cnt_in;
      end
   end

   // header index only runs while a length field is being collected
   `ANBR_ASSERT_CLK(a_idx_phase, clock, reset,
      hdr_idx_ff != 2'd0 |-> (phase_ff == PH_HDRLEN || phase_ff == PH_PKTLEN),
      "header index set outside a length field")
   // packet length field is two bytes
   `ANBR_ASSERT_CLK(a_pktlen_idx, clock, reset,
      phase_ff == PH_PKTLEN |-> hdr_idx_ff[1] == 1'b0,
      "packet length index out of range")
   // payload phase always has bytes left
   `ANBR_ASSERT_CLK(a_payload_left, clock, reset,
      phase_ff == PH_PAYLOAD |-> pkt_left_ff != 16'd0,
      "payload phase with no bytes left")
   // a start request restarts the header and clears the count
   `ANBR_ASSERT_CLK(a_start_clears, clock, reset,
      accept && req_type == REQ_START |=> phase_ff == PH_HDRMARK && rcv_cnt_ff == 32'd0,
      "start request did not restart the transfer")

endmodule

>>> src/anbr_out_stage.sv
// response register between the state machine and the response channel
`include "ack_nak_packet_stream_receiver_core_assert.svh"
module anbr_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  anbr_pkg::result_type result,
   output logic                 can_load,
   anbr_rsp_if.source           rsp_chan
);
   import anbr_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // free when empty or being drained this cycle
   assign can_load = !valid_ff || rsp_chan.ready;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   // drive the response channel
   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.reply_valid     = data_ff.reply_valid;
   assign rsp_chan.reply_byte      = data_ff.reply_byte;
   assign rsp_chan.payload_valid   = data_ff.payload_valid;
   assign rsp_chan.payload_byte    = data_ff.payload_byte;
   assign rsp_chan.transfer_done   = data_ff.transfer_done;
   assign rsp_chan.transfer_failed = data_ff.transfer_failed;
   assign rsp_chan.declared_length = data_ff.declared_length;
   assign rsp_chan.bytes_received  = data_ff.bytes_received;

   // a loaded request always shows up as a response next cycle
   `ANBR_ASSERT_CLK(a_load_shows, clock, reset, load |=> valid_ff,
      "loaded request not presented")
   // never overwrite a response that is still waiting
   `ANBR_ASSERT_CLK(a_no_overwrite, clock, reset, valid_ff && !rsp_chan.ready |-> !load,
      "pending response overwritten")
   // the last payload byte of a packet can only come with an ack
   `ANBR_ASSERT_CLK(a_payload_reply, clock, reset,
      valid_ff && data_ff.payload_valid && data_ff.reply_valid |->
         data_ff.reply_byte == BYTE_ACK,
      "payload byte paired with a non-ack reply")

endmodule

>>> src/ack_nak_packet_stream_receiver_core.sv
// top level of the ack/nak packet stream receiver core
// Takes one request per clock and returns exactly one response for each,
// in the cycle after acceptance, through a single response register. A start
// request restarts the transfer and answers 0x07; link bytes walk the header,
// packet markers and payload, answering ack/nak and forwarding payload bytes.
// Sustained rate is one request per cycle: the state machine updates its
// phase and counters in the accept cycle, and req_chan.ready drops only while
// the response register holds a result that rsp_chan has not taken.
// csr writes set the length check enable (index 0) and expected total
// (index 1); write them only while no request is in flight.
module ack_nak_packet_stream_receiver_core (
   input  logic        clock,
   input  logic        reset,
   anbr_req_if.sink    req_chan,
   anbr_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import anbr_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   logic       can_load;
   logic       accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEN_CHECK_EN: cfg_ff.len_check_en <= csr_wdata[0];
            CSR_EXP_TOTAL:    cfg_ff.exp_total    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // request handshake
   assign req_chan.ready = can_load;
   assign accept         = req_chan.valid && can_load;

   anbr_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_chan.req_type),
      .rx_byte  (req_chan.rx_byte),
      .cfg      (cfg_ff),
      .result   (result)
   );

   anbr_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> bench/tb_ack_nak_packet_stream_receiver_core.sv
// testbench for the ack/nak packet stream receiver core: queued link requests, predicted responses
module tb_ack_nak_packet_stream_receiver_core;
   import anbr_pkg::*;

   // last position of the declared length and of the packet length
   localparam logic [1:0] DECL_LEN_LAST_POS = 2'd3;
   localparam logic [1:0] PKT_LEN_LAST_POS  = 2'd1;
   // counted budget; phase overshoot, open transfers and directed requests add the rest
   localparam int unsigned RANDOM_ITEMS     = 720;
   localparam int unsigned PHASE_COUNT      = 8;
   localparam int unsigned LONG_HOLD_CYCLES = 80;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } link_req_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   anbr_req_if req_if ();
   anbr_rsp_if rsp_if ();

   ack_nak_packet_stream_receiver_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // requests waiting to be driven and responses still owed by the block
   link_req_type link_bytes_q[$];
   result_type   rx_results_q[$];
   int unsigned stim_count  = 0;
   int unsigned error_count = 0;
   bit          req_taken     = 1'b0;
   bit          no_idle       = 1'b0;
   bit          hold_request  = 1'b0;
   int unsigned gap_left      = 0;
   int unsigned stall_left    = 0;
   int unsigned hold_left     = 0;

   // receiver state and register copies of the predictor
   logic [2:0]  rx_phase      = PH_IDLE;
   logic [1:0]  hdr_pos       = '0;
   logic [31:0] decl_len      = '0;
   logic [15:0] pkt_remaining = '0;
   logic [31:0] payload_count = '0;
   logic        chk_enable    = 1'b0;
   logic [31:0] chk_total     = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5000000;
      $display("[ack_nak_packet_stream_receiver_core] ERROR");
      $finish;
   end

   // next receiver response for one request, advancing the predictor state
   function automatic result_type receive_step(logic kind, logic [7:0] b);
      result_type r;
      r = '0;
      if (kind == REQ_START) begin
         rx_phase      = PH_HDRMARK;
         hdr_pos       = '0;
         decl_len      = '0;
         pkt_remaining = '0;
         payload_count = '0;
         r.reply_valid = 1'b1;
         r.reply_byte  = BYTE_RECV_DATA;
      end else begin
         case (rx_phase)
            PH_HDRMARK: begin
               if (b == MARK_START) begin
                  rx_phase = PH_HDRLEN;
                  hdr_pos  = '0;
               end else begin
                  rx_phase      = PH_FAILED;
                  r.reply_valid = 1'b1;
                  r.reply_byte  = BYTE_NAK;
               end
            end
            PH_HDRLEN: begin
               decl_len = {decl_len[23:0], b};
               if (hdr_pos == DECL_LEN_LAST_POS) begin
                  hdr_pos       = '0;
                  rx_phase      = PH_MARKER;
                  r.reply_valid = 1'b1;
                  r.reply_byte  = BYTE_ACK;
               end else begin
                  hdr_pos = hdr_pos + 2'd1;
               end
            end
            PH_MARKER: begin
               r.reply_valid = 1'b1;
               r.reply_byte  = BYTE_ACK;
               if (b == MARK_PACKET) begin
                  rx_phase      = PH_PKTLEN;
                  hdr_pos       = '0;
                  pkt_remaining = '0;
                  r.reply_valid = 1'b0;
                  r.reply_byte  = '0;
               end else if (b == MARK_END) begin
                  rx_phase = PH_DONE;
                  if (chk_enable && payload_count != chk_total) r.reply_byte = BYTE_NAK;
               end
            end
            PH_PKTLEN: begin
               pkt_remaining = {pkt_remaining[7:0], b};
               if (hdr_pos == PKT_LEN_LAST_POS) begin
                  hdr_pos = '0;
                  if (pkt_remaining == '0) begin
                     rx_phase      = PH_MARKER;
                     r.reply_valid = 1'b1;
                     r.reply_byte  = BYTE_ACK;
                  end else begin
                     rx_phase = PH_PAYLOAD;
                  end
               end else begin
                  hdr_pos = PKT_LEN_LAST_POS;
               end
            end
            PH_PAYLOAD: begin
               r.payload_valid = 1'b1;
               r.payload_byte  = b;
               payload_count   = payload_count + 32'd1;
               pkt_remaining   = pkt_remaining - 16'd1;
               if (pkt_remaining == '0) begin
                  rx_phase      = PH_MARKER;
                  r.reply_valid = 1'b1;
                  r.reply_byte  = BYTE_ACK;
               end
            end
            default: ;
         endcase
      end
      r.transfer_done   = (rx_phase == PH_DONE);
      r.transfer_failed = (rx_phase == PH_FAILED);
      r.declared_length = decl_len;
      r.bytes_received  = payload_count;
      return r;
   endfunction

   // mostly short idle stretches, a few long ones
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) note_failure($sformatf("%s expected %h got %h", name, want, got));
   endtask

   // request driver: one request held until taken, then an optional gap
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_if.valid || req_taken) begin
         if (req_taken) gap_left = (no_idle || $urandom_range(0, 99) < 65) ? 0 : idle_len();
         if (gap_left > 0 || link_bytes_q.size() == 0) begin
            req_if.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            link_req_type it;
            it = link_bytes_q.pop_front();
            req_if.req_type <= it.kind;
            req_if.rx_byte  <= it.data;
            req_if.valid    <= 1'b1;
         end
      end
      req_taken = 1'b0;
   end

   // response ready: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (no_idle) begin
         rsp_if.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_if.ready <= 1'b0;
         stall_left = idle_len() - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor: register writes, accepted requests, accepted responses
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rx_phase      = PH_IDLE;
         hdr_pos       = '0;
         decl_len      = '0;
         pkt_remaining = '0;
         payload_count = '0;
         chk_enable    = 1'b0;
         chk_total     = '0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LEN_CHECK_EN) chk_enable = csr_wdata[0];
            else chk_total = csr_wdata;
         end
         if (req_if.valid && req_if.ready) begin
            rx_results_q.push_back(receive_step(req_if.req_type, req_if.rx_byte));
            req_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (rx_results_q.size() == 0) begin
               note_failure("response with no request outstanding");
            end else begin
               want = rx_results_q.pop_front();
               got.reply_valid     = rsp_if.reply_valid;
               got.reply_byte      = rsp_if.reply_byte;
               got.payload_valid   = rsp_if.payload_valid;
               got.payload_byte    = rsp_if.payload_byte;
               got.transfer_done   = rsp_if.transfer_done;
               got.transfer_failed = rsp_if.transfer_failed;
               got.declared_length = rsp_if.declared_length;
               got.bytes_received  = rsp_if.bytes_received;
               check_field("reply_valid", 32'(want.reply_valid), 32'(got.reply_valid));
               check_field("reply_byte", 32'(want.reply_byte), 32'(got.reply_byte));
               check_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
               check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
               check_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
               check_field("transfer_failed", 32'(want.transfer_failed),
                           32'(got.transfer_failed));
               check_field("declared_length", want.declared_length, got.declared_length);
               check_field("bytes_received", want.bytes_received, got.bytes_received);
            end
         end
      end
   end

   task automatic push_req(logic kind, logic [7:0] b, bit counted);
      link_req_type it;
      it.kind = kind;
      it.data = b;
      link_bytes_q.push_back(it);
      if (counted) stim_count++;
   endtask

   // packet marker, big-endian length, random payload
   task automatic push_packet(logic [15:0] len);
      push_req(REQ_BYTE, MARK_PACKET, 1'b1);
      push_req(REQ_BYTE, len[15:8], 1'b1);
      push_req(REQ_BYTE, len[7:0], 1'b1);
      repeat (len) push_req(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b1);
   endtask

   // byte in the marker wait that is neither packet nor end marker
   task automatic push_noise_marker();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == MARK_PACKET || b == MARK_END);
      push_req(REQ_BYTE, b, 1'b1);
   endtask

   // one transfer, mostly well formed; some are cut short or fail the header
   task automatic push_transfer(bit omit_end);
      logic [7:0]  b;
      logic [31:0] dlen;
      logic [15:0] len;
      int unsigned total, left, style, n, cut;
      push_req(REQ_START, 8'($urandom_range(0, 255)), 1'b1);
      style = $urandom_range(0, 19);
      // bad start marker, then a few bytes that the failed receiver drops
      if (style == 0) begin
         do b = 8'($urandom_range(0, 255)); while (b == MARK_START);
         push_req(REQ_BYTE, b, 1'b1);
         n = $urandom_range(0, 2);
         repeat (n) push_req(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0);
         return;
      end
      // start right after start
      if (style == 1) return;
      push_req(REQ_BYTE, MARK_START, 1'b1);
      case ($urandom_range(0, 9))
         0:       dlen = '0;
         1:       dlen = '1;
         default: dlen = $urandom;
      endcase
      // header cut off inside the declared length
      if (style == 2) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) push_req(REQ_BYTE, dlen[31 - 8 * i -: 8], 1'b1);
         return;
      end
      for (int i = 0; i < 4; i++) push_req(REQ_BYTE, dlen[31 - 8 * i -: 8], 1'b1);
      // aim at the expected total half the time when the length check is on and the total is at most 64
      if (chk_enable && chk_total <= 64 && $urandom_range(0, 1) == 1) total = chk_total;
      else total = $urandom_range(0, 40);
      left = total;
      while (left > 0) begin
         case ($urandom_range(0, 11))
            0: push_noise_marker();
            1: push_packet('0);
            2: begin
               // broken packet: stop somewhere in length or payload
               if ($urandom_range(0, 2) == 0) begin
                  len = 16'($urandom_range(2, 12));
                  cut = $urandom_range(1, len + 2);
                  for (int k = 0; k < cut; k++) begin
                     if (k == 0) b = MARK_PACKET;
                     else if (k == 1) b = len[15:8];
                     else if (k == 2) b = len[7:0];
                     else b = 8'($urandom_range(0, 255));
                     push_req(REQ_BYTE, b, 1'b1);
                  end
                  return;
               end
               push_noise_marker();
            end
            default: begin
               len = 16'($urandom_range(1, 12));
               if (len > left) len = 16'(left);
               push_packet(len);
               left -= len;
            end
         endcase
      end
      if (!omit_end) begin
         push_req(REQ_BYTE, MARK_END, 1'b1);
         n = $urandom_range(0, 2);
         repeat (n) push_req(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // hold the sender until every owed response has come back
   task automatic wait_drained();
      while (link_bytes_q.size() != 0 || req_if.valid || rx_results_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [31:0] total;
      int unsigned target;
      bit          carry_end;
      carry_end       = 1'b0;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_LEN_CHECK_EN;
      csr_wdata       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: byte while idle, bad header, extremes, zero and short packets
      push_req(REQ_BYTE, 8'hFF, 1'b0);
      push_req(REQ_START, 8'hFF, 1'b0);
      push_req(REQ_BYTE, 8'h00, 1'b0);
      push_req(REQ_START, 8'h00, 1'b0);
      push_req(REQ_BYTE, MARK_START, 1'b0);
      repeat (4) push_req(REQ_BYTE, 8'hFF, 1'b0);
      push_req(REQ_BYTE, 8'h00, 1'b0);
      push_packet('0);
      push_req(REQ_BYTE, MARK_PACKET, 1'b0);
      push_req(REQ_BYTE, 8'h00, 1'b0);
      push_req(REQ_BYTE, 8'h02, 1'b0);
      push_req(REQ_BYTE, 8'h00, 1'b0);
      push_req(REQ_BYTE, 8'hFF, 1'b0);
      push_req(REQ_BYTE, MARK_END, 1'b0);
      // byte while done, then restart with a zero length header
      push_req(REQ_BYTE, MARK_PACKET, 1'b0);
      push_req(REQ_START, 8'h5A, 1'b0);
      push_req(REQ_BYTE, MARK_START, 1'b0);
      repeat (4) push_req(REQ_BYTE, 8'h00, 1'b0);
      // largest packet length, left open so the next start cuts it
      push_req(REQ_BYTE, MARK_PACKET, 1'b0);
      push_req(REQ_BYTE, 8'hFF, 1'b0);
      push_req(REQ_BYTE, 8'hFF, 1'b0);
      push_req(REQ_BYTE, 8'h5A, 1'b0);

      // random phases, each with its own register setting
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_drained();
         case (ph % 4)
            0:       total = $urandom_range(0, 40);
            1:       total = '1;
            2:       total = '0;
            default: total = $urandom;
         endcase
         write_csr(CSR_LEN_CHECK_EN, {31'b0, ((ph / 2) % 2 == 0)});
         write_csr(CSR_EXP_TOTAL, total);
         @(posedge clock);
         no_idle = (ph == 3 || ph == 6);
         if (ph == 2) hold_request = 1'b1;
         // end marker of a transfer opened before the register change
         if (carry_end) push_req(REQ_BYTE, MARK_END, 1'b1);
         carry_end = 1'b0;
         target = stim_count + RANDOM_ITEMS / PHASE_COUNT;
         while (stim_count < target) push_transfer(1'b0);
         if (ph % 2 == 1) begin
            push_transfer(1'b1);
            carry_end = 1'b1;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (rx_results_q.size() != 0) note_failure("responses still owed at end of run");
      if (error_count == 0) begin
         $display("[ack_nak_packet_stream_receiver_core] OK");
      end else begin
         $display("[ack_nak_packet_stream_receiver_core] ERROR");
      end
      $finish;
   end

endmodule
